// ===== hw/rtl/bmpc_pkg.sv =====
// Shared constants and codes for the BMP pixel to RGBA converter.
package bmpc_pkg;

  localparam int MAX_DIM_DEF     = 4096;
  localparam int PAL_ENTRIES_DEF = 256;

  localparam int CFG_W       = 13;
  localparam int CMD_W       = 2;
  localparam int REG_IDX_W   = 2;
  localparam int POS_W       = 12;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM_UP = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH     = 2'd3;

  localparam logic [1:0] DEPTH_PAL  = 2'd0;
  localparam logic [1:0] DEPTH_BGR  = 2'd1;
  localparam logic [1:0] DEPTH_BGRA = 2'd2;

  localparam logic [1:0] PHASE_BGR_LAST  = 2'd2;
  localparam logic [1:0] PHASE_BGRA_LAST = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ===== hw/rtl/bmp_pixel_to_rgba_converter_top.sv =====
// BMP pixel-data byte stream to RGBA pixel converter, top level.
// Takes one word per clock: palette writes, pixel-data bytes (row padding included) and
// restart commands, and returns one RGBA pixel with its destination row and column for each
// completed source pixel. A word is taken every cycle as long as the output side drains;
// a pixel's final byte passes into stage 1, alongside the palette memory read, and then into
// the output register. The palette memory is not cleared at reset: an entry must be written
// before a pixel uses it. Position counters start at zero after reset and after a restart
// command.
module bmp_pixel_to_rgba_converter_top #(
  parameter int MAX_DIM         = bmpc_pkg::MAX_DIM_DEF,
  parameter int PALETTE_ENTRIES = bmpc_pkg::PAL_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bmpc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bmpc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // data_byte, palette_index, palette_blue, palette_green, palette_red
  input  logic [bmpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command
  input  logic [bmpc_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red, green, blue, alpha, pixel_row, pixel_column
  output logic [bmpc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // last_pixel
  output logic                               out_tlast
);

  localparam int CW     = bmpc_pkg::CFG_W;
  localparam int PW     = bmpc_pkg::POS_W;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  // configuration
  logic [CW-1:0] width_r, height_r;
  logic          bottom_up_r;
  logic [1:0]    depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CW'(1);
      height_r    <= CW'(1);
      bottom_up_r <= 1'b1;
      depth_r     <= bmpc_pkg::DEPTH_BGR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmpc_pkg::REG_WIDTH:     width_r     <= cfg_wdata;
        bmpc_pkg::REG_HEIGHT:    height_r    <= cfg_wdata;
        bmpc_pkg::REG_BOTTOM_UP: bottom_up_r <= cfg_wdata[0];
        bmpc_pkg::REG_DEPTH:     depth_r     <= cfg_wdata[1:0];
      endcase
    end
  end

  // input fields
  logic [7:0] in_byte, in_idx, in_blue, in_green, in_red;
  assign in_byte  = in_tdata[7:0];
  assign in_idx   = in_tdata[15:8];
  assign in_blue  = in_tdata[23:16];
  assign in_green = in_tdata[31:24];
  assign in_red   = in_tdata[39:32];

  // effective dimensions
  logic [CW-1:0] w_eff, h_eff;
  always_comb begin
    if (width_r == '0)                   w_eff = CW'(1);
    else if (32'(width_r) > MAX_DIM)     w_eff = CW'(MAX_DIM);
    else                                 w_eff = width_r;
    if (height_r == '0)                  h_eff = CW'(1);
    else if (32'(height_r) > MAX_DIM)    h_eff = CW'(MAX_DIM);
    else                                 h_eff = height_r;
  end

  // position state
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [1:0]    phase_r, phase_nxt, pad_r, pad_nxt;
  logic [7:0]    hb_r, hb_nxt, hg_r, hg_nxt, hr_r, hr_nxt;

  // stage 1 and output register
  logic          s1_v_r, s1_pal_r, s1_inr_r, s1_last_r;
  logic [7:0]    s1_red_r, s1_green_r, s1_blue_r, s1_alpha_r;
  logic [PW-1:0] s1_row_r, s1_col_r;
  logic          out_v_r, out_last_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [PW-1:0] out_row_r, out_col_r;
  logic [23:0]   pal_rd_r;

  logic acc, s1_adv;
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  // per-word decode
  logic          px_done, pal_re, pal_we, idx_ok, byte_ok;
  logic          last_col, last_row;
  logic [7:0]    px_red, px_green, px_blue, px_alpha;
  logic [CW-1:0] dest;
  logic [1:0]    pad_new, final_phase;

  assign idx_ok  = {1'b0, in_idx}  < 9'(PALETTE_ENTRIES);
  assign byte_ok = {1'b0, in_byte} < 9'(PALETTE_ENTRIES);
  assign pal_we  = acc && (in_tuser == bmpc_pkg::CMD_PAL_WRITE) && idx_ok;

  assign last_col = ({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, w_eff};
  assign last_row = ({1'b0, row_r} + (CW+1)'(1)) >= {1'b0, h_eff};

  always_comb begin
    if (!bottom_up_r)        dest = row_r;
    else if (row_r < h_eff)  dest = h_eff - CW'(1) - row_r;
    else                     dest = '0;
  end

  // padding bytes: 1 byte/pixel pads -w, 3 bytes/pixel pads w (mod 4), 4 bytes none
  always_comb begin
    unique case (depth_r)
      bmpc_pkg::DEPTH_PAL: pad_new = 2'(-w_eff[1:0]);
      bmpc_pkg::DEPTH_BGR: pad_new = w_eff[1:0];
      default:             pad_new = 2'd0;
    endcase
    final_phase = (depth_r == bmpc_pkg::DEPTH_BGR) ? bmpc_pkg::PHASE_BGR_LAST
                                                   : bmpc_pkg::PHASE_BGRA_LAST;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    hb_nxt    = hb_r;
    hg_nxt    = hg_r;
    hr_nxt    = hr_r;
    px_done   = 1'b0;
    pal_re    = 1'b0;
    px_red    = hr_r;
    px_green  = hg_r;
    px_blue   = hb_r;
    px_alpha  = bmpc_pkg::ALPHA_OPAQUE;
    unique case (in_tuser)
      bmpc_pkg::CMD_RESTART: begin
        col_nxt   = '0;
        row_nxt   = '0;
        phase_nxt = '0;
        pad_nxt   = '0;
        hb_nxt    = '0;
        hg_nxt    = '0;
        hr_nxt    = '0;
      end
      bmpc_pkg::CMD_PIXEL: begin
        if (pad_r != 2'd0) begin
          // drop padding; close the row on its final byte
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : row_r + CW'(1);
          end
        end else if (depth_r == bmpc_pkg::DEPTH_PAL) begin
          px_done = 1'b1;
          pal_re  = byte_ok;
        end else if (phase_r < final_phase) begin
          if (phase_r == 2'd0)      hb_nxt = in_byte;
          else if (phase_r == 2'd1) hg_nxt = in_byte;
          else                      hr_nxt = in_byte;
          phase_nxt = phase_r + 2'd1;
        end else begin
          px_done = 1'b1;
          if (depth_r == bmpc_pkg::DEPTH_BGR) begin
            px_red = in_byte;
          end else begin
            px_alpha = in_byte;
          end
        end
        if (px_done) begin
          phase_nxt = '0;
          if (last_col) begin
            col_nxt = '0;
            if (pad_new == 2'd0) row_nxt = last_row ? '0 : row_r + CW'(1);
            else                 pad_nxt = pad_new;
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      pad_r   <= '0;
      hb_r    <= '0;
      hg_r    <= '0;
      hr_r    <= '0;
    end else if (acc) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
      hb_r    <= hb_nxt;
      hg_r    <= hg_nxt;
      hr_r    <= hr_nxt;
    end
  end

  // palette memory
  logic [23:0] pal_mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[in_idx[PAL_AW-1:0]] <= {in_red, in_green, in_blue};
    // hold the read data while stage 1 waits
    if (acc && pal_re) pal_rd_r <= pal_mem[in_byte[PAL_AW-1:0]];
  end

  // stage 1: position and held bytes wait here for the palette read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= (in_tuser == bmpc_pkg::CMD_PIXEL) && px_done;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && px_done) begin
      s1_pal_r   <= (depth_r == bmpc_pkg::DEPTH_PAL);
      s1_inr_r   <= byte_ok;
      s1_red_r   <= px_red;
      s1_green_r <= px_green;
      s1_blue_r  <= px_blue;
      s1_alpha_r <= px_alpha;
      s1_row_r   <= dest[PW-1:0];
      s1_col_r   <= col_r[PW-1:0];
      s1_last_r  <= last_col && last_row;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      if (s1_pal_r) begin
        out_red_r   <= s1_inr_r ? pal_rd_r[23:16] : 8'd0;
        out_green_r <= s1_inr_r ? pal_rd_r[15:8]  : 8'd0;
        out_blue_r  <= s1_inr_r ? pal_rd_r[7:0]   : 8'd0;
      end else begin
        out_red_r   <= s1_red_r;
        out_green_r <= s1_green_r;
        out_blue_r  <= s1_blue_r;
      end
      out_alpha_r <= s1_alpha_r;
      out_row_r   <= s1_row_r;
      out_col_r   <= s1_col_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_col_r, out_row_r, out_alpha_r, out_blue_r, out_green_r, out_red_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/bmpc_checker.sv =====
// Port-level assertions for the BMP pixel to RGBA converter, bound to the top level.
module bmpc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [bmpc_pkg::CMD_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bmpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // with the output register empty, the input side must never stall
  a_skid_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while output register empty");

  // a fresh result follows an accepted pixel byte through stage 1 and the output register
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(in_tvalid && in_tready && (in_tuser == bmpc_pkg::CMD_PIXEL), 2))
    else $error("result appeared without a pixel byte");

endmodule

bind bmp_pixel_to_rgba_converter_top bmpc_checker u_bmpc_checker (.*);
